// ===== src/hitt_pkg.sv =====
package hitt_pkg;

  localparam int CAPACITY    = 63;
  localparam int VALUE_BITS  = 32;
  localparam int STORE_DEPTH = 63;
  localparam int STACK_DEPTH = 6;
  localparam int IDX_W       = 6;
  localparam int SP_W        = 3;

  localparam logic [1:0] MODE_APPEND   = 2'd0;
  localparam logic [1:0] MODE_TRAVERSE = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  localparam logic [1:0] ORDER_INORDER   = 2'd0;
  localparam logic [1:0] ORDER_PREORDER  = 2'd1;
  localparam logic [1:0] ORDER_POSTORDER = 2'd2;

  localparam logic [1:0] PHASE_ARRIVE = 2'd0;
  localparam logic [1:0] PHASE_LEFT   = 2'd1;
  localparam logic [1:0] PHASE_RIGHT  = 2'd2;

  localparam logic [2:0] ST_VISITED  = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [IDX_W-1:0]   out_index;
    logic [2:0]         status;
    logic               last_flag;
  } out_item_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_FETCH
  } fsm_state_t;

  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic step;     // one stack iteration
    logic load_out; // move fetched entry into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic walk_start; // accepted beat starts a non-empty walk
    logic emit;       // current stack step visits its slot
    logic last;       // fetched entry is the final one of the walk
    logic out_free;   // output register can take a beat
  } dp_status_t;

endpackage

// ===== src/heap_indexed_tree_traversal.sv =====
// Append, clear and empty traverse: the result is written to the output register on accept.
// Traverse: one stack step per cycle while walking, then a fetch state for each visited
// slot that loads the read entry once the output register can take a beat.
// A new input beat is taken only when idle and once the output register can take a beat.
// Synchronous active-low reset empties the tree and sets walk_order to inorder; store
// contents are not cleared.
module heap_indexed_tree_traversal
  import hitt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  hitt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hitt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== src/hitt_ctrl.sv =====
module hitt_ctrl
  import hitt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t stat,
  output dp_cmd_t    cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready   = stat.out_free;
        cmd.accept = in_valid && stat.out_free;
        if (cmd.accept && stat.walk_start) begin
          state_nxt = FSM_WALK;
        end
      end
      FSM_WALK: begin
        cmd.step = 1'b1;
        if (stat.emit) begin
          state_nxt = FSM_FETCH;
        end
      end
      FSM_FETCH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = stat.last ? FSM_IDLE : FSM_WALK;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

endmodule

// ===== src/hitt_dp.sv =====
module hitt_dp
  import hitt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_data,
  output out_item_t  out_data,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_cmd_t    cmd,
  output dp_status_t stat
);

  logic [VALUE_BITS-1:0] store_mem [STORE_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;

  logic [IDX_W-1:0] count_r;
  logic [IDX_W-1:0] cursor_r;
  logic [1:0]       order_r;
  logic [1:0]       emit_ph_r;
  logic             last_r;
  logic [IDX_W-1:0] fetch_idx_r;

  logic [IDX_W-1:0] stk_idx_r [STACK_DEPTH];
  logic [1:0]       stk_ph_r  [STACK_DEPTH];
  logic [SP_W-1:0]  sp_r;

  out_item_t out_r;
  logic      out_valid_r;
  logic      out_valid_nxt;

  logic [SP_W-1:0]       top_ptr;
  logic [IDX_W-1:0]      top_idx;
  logic [1:0]            top_ph;
  logic [IDX_W:0]        child;
  logic                  push;
  logic                  can_append;
  logic [1:0]            walk_ph;
  logic signed [VALUE_BITS-1:0] in_trunc;
  logic signed [VALUE_BITS-1:0] rd_signed;

  assign top_ptr   = sp_r - SP_W'(1);
  assign top_idx   = stk_idx_r[top_ptr];
  assign top_ph    = stk_ph_r[top_ptr];
  assign child     = {top_idx, 1'b0} + (IDX_W+1)'(1) + (IDX_W+1)'(top_ph);
  assign push      = (child < {1'b0, count_r}) && (sp_r < SP_W'(STACK_DEPTH));
  assign can_append = count_r < IDX_W'(CAPACITY);
  assign in_trunc  = VALUE_BITS'(in_data.data_value);
  assign rd_signed = rd_data_r;

  // walk_order 3 runs as inorder
  always_comb begin
    case (order_r)
      ORDER_PREORDER:  walk_ph = PHASE_ARRIVE;
      ORDER_POSTORDER: walk_ph = PHASE_RIGHT;
      default:         walk_ph = PHASE_LEFT;
    endcase
  end

  assign stat.walk_start = (in_data.mode == MODE_TRAVERSE) && (count_r != '0);
  assign stat.emit       = (top_ph == emit_ph_r);
  assign stat.last       = last_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.accept) begin
      case (in_data.mode)
        MODE_APPEND:   out_valid_nxt = 1'b1;
        MODE_TRAVERSE: out_valid_nxt = (count_r == '0);
        MODE_CLEAR:    out_valid_nxt = 1'b1;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // read data is held until the fetched beat is loaded
  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.mode == MODE_APPEND && can_append) begin
      store_mem[count_r] <= in_trunc;
    end
    if (cmd.step && stat.emit) begin
      rd_data_r <= store_mem[top_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_INORDER;
    end else if (cfg_valid) begin
      order_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.accept) begin
        case (in_data.mode)
          MODE_APPEND: begin
            if (can_append) begin
              count_r <= count_r + IDX_W'(1);
            end
          end
          MODE_TRAVERSE: begin
            cursor_r    <= '0;
            sp_r        <= SP_W'(1);
          end
          MODE_CLEAR: begin
            count_r     <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.step) begin
        if (top_ph >= PHASE_RIGHT) begin
          sp_r <= top_ptr;
        end else if (push) begin
          sp_r <= sp_r + SP_W'(1);
        end
        if (stat.emit) begin
          cursor_r <= cursor_r + IDX_W'(1);
        end
      end
    end
  end

  // payload and stack contents, no reset
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      emit_ph_r <= walk_ph;
      case (in_data.mode)
        MODE_APPEND: begin
          if (can_append) begin
            out_r.out_value <= 32'(in_trunc);
            out_r.out_index <= count_r;
            out_r.status    <= ST_APPENDED;
          end else begin
            out_r.out_value <= in_data.data_value;
            out_r.out_index <= '0;
            out_r.status    <= ST_FULL;
          end
          out_r.last_flag <= 1'b1;
        end
        MODE_TRAVERSE: begin
          stk_idx_r[0]    <= '0;
          stk_ph_r[0]     <= PHASE_ARRIVE;
          out_r.out_value <= '0;
          out_r.out_index <= '0;
          out_r.status    <= ST_EMPTY;
          out_r.last_flag <= 1'b1;
        end
        MODE_CLEAR: begin
          out_r.out_value <= '0;
          out_r.out_index <= '0;
          out_r.status    <= ST_CLEARED;
          out_r.last_flag <= 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.step) begin
      if (top_ph < PHASE_RIGHT) begin
        stk_ph_r[top_ptr] <= top_ph + 2'd1;
        if (push) begin
          stk_idx_r[sp_r[SP_W-1:0]] <= child[IDX_W-1:0];
          stk_ph_r[sp_r[SP_W-1:0]]  <= PHASE_ARRIVE;
        end
      end
      if (stat.emit) begin
        fetch_idx_r <= top_idx;
        last_r      <= (cursor_r == count_r - IDX_W'(1));
      end
    end
    if (cmd.load_out) begin
      out_r.out_value <= 32'(rd_signed);
      out_r.out_index <= fetch_idx_r;
      out_r.status    <= ST_VISITED;
      out_r.last_flag <= last_r;
    end
  end

endmodule

// ===== verif/heap_indexed_tree_traversal_tb.sv =====
module heap_indexed_tree_traversal_tb;
  import hitt_pkg::*;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam logic [1:0] ORDER_UNUSED = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data  = ORDER_INORDER;

  // shadow copy of the tree held by the block
  logic signed [31:0] shadow_store [STORE_DEPTH];
  int unsigned        shadow_count;
  logic [1:0]         shadow_order;
  out_item_t          tree_out_q [$];

  int in_idle_pct;
  int out_stall_pct;
  int err_cnt;
  int beats_in;
  int beats_out;
  int walks_done;
  int drops_seen;
  int drains_done;

  always #1 clk = ~clk;

  heap_indexed_tree_traversal dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic out_item_t tree_beat(logic signed [31:0] v, int unsigned slot,
                                          logic [2:0] st, logic lst);
    out_item_t o;
    o.out_value = v;
    o.out_index = slot[IDX_W-1:0];
    o.status    = st;
    o.last_flag = lst;
    return o;
  endfunction

  // depth-first walk over the shadow tree, slot/phase stack as in hardware
  function automatic void walk_tree();
    int unsigned slot_stk [STACK_DEPTH];
    logic [1:0]  ph_stk [STACK_DEPTH];
    int          sp;
    int unsigned slot;
    int unsigned child;
    logic [1:0]  ph;
    logic [1:0]  hit_ph;
    out_item_t   walk_q [$];
    hit_ph = (shadow_order == ORDER_PREORDER)  ? PHASE_ARRIVE :
             (shadow_order == ORDER_POSTORDER) ? PHASE_RIGHT  : PHASE_LEFT;
    slot_stk[0] = 0;
    ph_stk[0]   = PHASE_ARRIVE;
    sp          = 1;
    while (sp > 0) begin
      slot = slot_stk[sp-1];
      ph   = ph_stk[sp-1];
      if (ph == hit_ph)
        walk_q.push_back(tree_beat(shadow_store[slot], slot, ST_VISITED, 1'b0));
      if (ph == PHASE_RIGHT) begin
        sp--;
      end else begin
        ph_stk[sp-1] = ph + 2'd1;
        child = 2 * slot + 1 + ph;
        if (child < shadow_count) begin
          slot_stk[sp] = child;
          ph_stk[sp]   = PHASE_ARRIVE;
          sp++;
        end
      end
    end
    walk_q[walk_q.size()-1].last_flag = 1'b1;
    foreach (walk_q[i]) tree_out_q.push_back(walk_q[i]);
  endfunction

  function automatic void apply_tree_item(in_item_t it);
    case (it.mode)
      MODE_APPEND: begin
        if (shadow_count < CAPACITY) begin
          shadow_store[shadow_count] = it.data_value;
          tree_out_q.push_back(tree_beat(it.data_value, shadow_count, ST_APPENDED, 1'b1));
          shadow_count++;
        end else begin
          tree_out_q.push_back(tree_beat(it.data_value, 0, ST_FULL, 1'b1));
          drops_seen++;
        end
      end
      MODE_CLEAR: begin
        shadow_count = 0;
        tree_out_q.push_back(tree_beat('0, 0, ST_CLEARED, 1'b1));
      end
      MODE_TRAVERSE: begin
        walks_done++;
        if (shadow_count == 0)
          tree_out_q.push_back(tree_beat('0, 0, ST_EMPTY, 1'b1));
        else
          walk_tree();
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
    err_cnt++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (tree_out_q.size() == 0) begin
      report_mismatch("unexpected result beat", 64'(got), '0);
    end else begin
      want = tree_out_q.pop_front();
      if (got.out_value !== want.out_value)
        report_mismatch("out_value", 64'(got.out_value), 64'(want.out_value));
      if (got.out_index !== want.out_index)
        report_mismatch("out_index", 64'(got.out_index), 64'(want.out_index));
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.last_flag !== want.last_flag)
        report_mismatch("last_flag", 64'(got.last_flag), 64'(want.last_flag));
    end
  endtask

  // prediction and checking share one process so a beat in and a beat out
  // at the same edge are handled in a fixed order
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      shadow_order = ORDER_INORDER;
      tree_out_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) shadow_order = cfg_data;
      if (in_valid && in_ready) begin
        beats_in++;
        apply_tree_item(in_data);
      end
      if (out_valid && out_ready) begin
        beats_out++;
        check_result(out_data);
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [31:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.mode       <= mode;
    in_data.data_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tree_out_q.size() != 0) @(posedge clk);
    // an ignored item may still be in flight with nothing pending
    repeat (8) @(posedge clk);
    drains_done++;
  endtask

  task automatic write_order(input logic [1:0] order);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= order;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_tree();
    send_item(MODE_TRAVERSE, $urandom);
    send_item(MODE_UNUSED, $urandom);
    send_item(MODE_CLEAR, $urandom);
    send_item(MODE_TRAVERSE, 32'h0);
  endtask

  task automatic test_extreme_values();
    send_item(MODE_APPEND, 32'h8000_0000);
    send_item(MODE_APPEND, 32'h7fff_ffff);
    send_item(MODE_APPEND, 32'h0000_0000);
    send_item(MODE_APPEND, 32'hffff_ffff);
    send_item(MODE_APPEND, 32'h0000_0001);
    send_item(MODE_APPEND, 32'h5555_5555);
    send_item(MODE_APPEND, 32'haaaa_aaaa);
    send_item(MODE_TRAVERSE, 32'h0);
  endtask

  task automatic test_walk_orders();
    write_order(ORDER_PREORDER);
    send_item(MODE_TRAVERSE, 32'h0);
    write_order(ORDER_POSTORDER);
    send_item(MODE_TRAVERSE, 32'h0);
    write_order(ORDER_UNUSED);  // unused code walks inorder
    send_item(MODE_TRAVERSE, 32'h0);
    send_item(MODE_CLEAR, 32'h0);
    send_item(MODE_APPEND, $urandom);
    send_item(MODE_TRAVERSE, 32'h0);
    write_order(ORDER_INORDER);
  endtask

  task automatic test_full_tree();
    send_item(MODE_CLEAR, 32'h0);
    repeat (CAPACITY) send_item(MODE_APPEND, $urandom);
    send_item(MODE_APPEND, 32'h8000_0000);
    send_item(MODE_APPEND, $urandom);
    send_item(MODE_TRAVERSE, 32'h0);
    write_order(ORDER_PREORDER);
    send_item(MODE_TRAVERSE, 32'h0);
    write_order(ORDER_POSTORDER);
    send_item(MODE_TRAVERSE, 32'h0);
    // slot 0 is reused after a clear
    send_item(MODE_CLEAR, 32'h0);
    send_item(MODE_APPEND, $urandom);
    send_item(MODE_TRAVERSE, 32'h0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct, input logic [1:0] order,
                                     input int clear_pm);
    int         sent;
    int         k;
    logic [1:0] mode;
    write_order(order);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(999);
      if (k < clear_pm)           mode = MODE_CLEAR;
      else if (k < clear_pm + 25) mode = MODE_UNUSED;
      else if (k < 700)           mode = MODE_APPEND;
      else                        mode = MODE_TRAVERSE;
      send_item(mode, $urandom);
      if (mode != MODE_UNUSED) sent++;
      // hold off now and then until the block has emptied
      if ($urandom_range(39) == 0) wait_drain();
    end
  endtask

  initial begin
    in_idle_pct   = 8;
    out_stall_pct = 8;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_tree();
    test_extreme_values();
    test_walk_orders();
    out_stall_pct = 71;
    test_full_tree();
    test_random_traffic(90, 0, 0, ORDER_PREORDER, 20);
    test_random_traffic(90, 71, 0, ORDER_POSTORDER, 40);
    test_random_traffic(90, 0, 71, ORDER_INORDER, 80);
    test_random_traffic(90, 8, 8, ORDER_UNUSED, 8);
    wait_drain();

    $display("run: %0d input beats, %0d result beats, %0d walks, %0d appends dropped on full",
             beats_in, beats_out, walks_done, drops_seen);
    $display("all four walk_order codes, four idle/stall mixes, %0d full drains",
             drains_done);
    if (err_cnt == 0)
      $display("heap_indexed_tree_traversal_tb: PASS");
    else
      $display("heap_indexed_tree_traversal_tb: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results still pending", tree_out_q.size());
    $display("heap_indexed_tree_traversal_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/hitt_pkg.sv
src/hitt_ctrl.sv
src/hitt_dp.sv
src/heap_indexed_tree_traversal.sv
verif/heap_indexed_tree_traversal_tb.sv
